FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the weekly clock task timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/wctt_pkg.sv
// Package with the shared constants and types of the weekly clock task timer.
`timescale 1ns / 1ps
package wctt_pkg;

    localparam int unsigned MAX_TASKS = 8;
    localparam int unsigned SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [1:0]        slot_kind_t;
    typedef logic [15:0]       payload_t;

    // Operation codes of an input word
    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_SET_TIME = 3'd1;
    localparam logic [2:0] FUNC_ADD_CD   = 3'd2;
    localparam logic [2:0] FUNC_ADD_SCHED = 3'd3;
    localparam logic [2:0] FUNC_REMOVE   = 3'd4;

    // Slot kinds
    localparam slot_kind_t KIND_FREE      = 2'd0;
    localparam slot_kind_t KIND_COUNTDOWN = 2'd1;
    localparam slot_kind_t KIND_SCHEDULED = 2'd2;

    // Result word kinds
    localparam logic [1:0] RES_ADD_ACK = 2'd0;
    localparam logic [1:0] RES_FIRED   = 2'd1;
    localparam logic [1:0] RES_END     = 2'd2;

    localparam logic [15:0] RESYNC_RESET = 16'd3600;

endpackage

FILE: src/weekly_clock_task_timer.sv
// Top level of the weekly clock task timer: clock, slot table and result sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block keeps a weekly clock (seconds, minutes, hours, day 1..7; day 0 means
// the time is not valid) and a table of MAX_TASKS task slots. Each input word is
// one operation: tick, set_time, add countdown, add scheduled or remove. It
// produces zero or more add-acknowledge or task-fired words followed by one end
// word (last = 1) that carries the clock and the resync request. The block
// works on one input word at a time: in_ready is high only while the sequencer
// is idle, but a result word may still wait in the output register while the
// next input word is taken. A tick on a valid clock walks the slot table one
// slot per cycle through the payload memory (synchronous read) while no fired
// word waits for room in the output register. Each operation is held up for as
// long as a full output register holds back one of its words.
// The resync interval register may be written at any time the block is idle;
// it takes effect on the next tick.
module weekly_clock_task_timer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [5:0]  time_seconds,
    input  logic [5:0]  time_minutes,
    input  logic [4:0]  time_hours,
    input  logic [2:0]  time_day,
    input  logic [15:0] countdown_seconds,
    input  logic [7:0]  task_index,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  slot_index,
    output logic        success,
    output logic        request_time,
    output logic [5:0]  now_seconds,
    output logic [5:0]  now_minutes,
    output logic [4:0]  now_hours,
    output logic [2:0]  now_day,
    output logic        last
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    localparam wctt_pkg::slot_idx_t LAST_SLOT =
        wctt_pkg::SLOT_W'(wctt_pkg::MAX_TASKS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [1:0]                state_reg, state_next;
    wctt_pkg::slot_idx_t       scan_idx_reg, scan_idx_next;
    logic [15:0]               resync_interval_reg;
    logic [15:0]               resync_count_reg, resync_count_next;
    logic                      req_reg, req_next;

    logic [5:0]                sec_reg, sec_next;
    logic [5:0]                min_reg, min_next;
    logic [4:0]                hour_reg, hour_next;
    logic [2:0]                day_reg, day_next;

    // Slot kinds live in flops so that reset frees every slot at once
    wctt_pkg::slot_kind_t      slot_kind_reg [wctt_pkg::MAX_TASKS];
    wctt_pkg::slot_kind_t      slot_kind_next [wctt_pkg::MAX_TASKS];

    // Pending add, latched at accept
    wctt_pkg::slot_kind_t      add_kind_reg, add_kind_next;
    wctt_pkg::payload_t        add_payload_reg, add_payload_next;

    // Payload memory: countdown remaining or packed day/hour/minute
    wctt_pkg::payload_t        payload_mem [wctt_pkg::MAX_TASKS];
    wctt_pkg::payload_t        rdata_reg;
    wctt_pkg::slot_idx_t       rd_addr;
    logic                      mem_we;
    wctt_pkg::slot_idx_t       mem_waddr;
    wctt_pkg::payload_t        mem_wdata;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_kind_reg, out_kind_next;
    logic [2:0]                out_slot_reg, out_slot_next;
    logic                      out_success_reg, out_success_next;
    logic                      out_req_reg, out_req_next;
    logic                      out_last_reg, out_last_next;
    logic [5:0]                out_sec_reg;
    logic [5:0]                out_min_reg;
    logic [4:0]                out_hour_reg;
    logic [2:0]                out_day_reg;
    logic                      out_load;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                      in_fire;
    logic                      out_room;
    wctt_pkg::slot_kind_t      cur_kind;
    wctt_pkg::payload_t        dec_payload;
    logic                      sched_match;
    logic                      fire;
    logic                      advance;
    logic                      free_found;
    wctt_pkg::slot_idx_t       free_idx;
    logic [15:0]               count_inc;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_room = !out_valid_reg || out_ready;

    // Slot under the scan pointer; its payload arrived from memory last cycle
    assign cur_kind    = slot_kind_reg[scan_idx_reg];
    assign dec_payload = rdata_reg - 16'd1;
    assign sched_match = (rdata_reg[13:11] == day_reg) &&
                         (rdata_reg[10:6] == hour_reg) &&
                         (rdata_reg[5:0] == min_reg);
    assign fire = ((cur_kind == wctt_pkg::KIND_COUNTDOWN) && (dec_payload == 16'd0)) ||
                  ((cur_kind == wctt_pkg::KIND_SCHEDULED) && sched_match);
    // Hold the slot while a fired word cannot enter the output register
    assign advance = !fire || out_room;

    assign count_inc = resync_count_reg + 16'd1;

    // First free slot, lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = wctt_pkg::MAX_TASKS - 1; i >= 0; i--)
        begin
            if (slot_kind_reg[i] == wctt_pkg::KIND_FREE)
            begin
                free_found = 1'b1;
                free_idx   = wctt_pkg::SLOT_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        resync_count_next = resync_count_reg;
        req_next          = req_reg;
        sec_next          = sec_reg;
        min_next          = min_reg;
        hour_next         = hour_reg;
        day_next          = day_reg;
        slot_kind_next    = slot_kind_reg;
        add_kind_next     = add_kind_reg;
        add_payload_next  = add_payload_reg;

        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = scan_idx_reg;
        mem_wdata = dec_payload;

        out_load         = 1'b0;
        out_kind_next    = out_kind_reg;
        out_slot_next    = out_slot_reg;
        out_success_next = out_success_reg;
        out_req_next     = out_req_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // rd_addr stays at slot 0 so a tick finds its first payload ready
                if (in_fire)
                begin
                    req_next   = 1'b0;
                    state_next = ST_END;
                    case (func)
                        wctt_pkg::FUNC_TICK:
                        begin
                            if (day_reg == 3'd0)
                            begin
                                req_next = 1'b1;
                            end
                            else
                            begin
                                // Advance the clock, carrying through the units
                                if (sec_reg < 6'd59)
                                begin
                                    sec_next = sec_reg + 6'd1;
                                end
                                else
                                begin
                                    sec_next = 6'd0;
                                    if (min_reg < 6'd59)
                                    begin
                                        min_next = min_reg + 6'd1;
                                    end
                                    else
                                    begin
                                        min_next = 6'd0;
                                        if (hour_reg < 5'd23)
                                        begin
                                            hour_next = hour_reg + 5'd1;
                                        end
                                        else
                                        begin
                                            hour_next = 5'd0;
                                            day_next  = (day_reg < 3'd7) ?
                                                        day_reg + 3'd1 : 3'd1;
                                        end
                                    end
                                end
                                // Count valid ticks toward the next resync request
                                if (count_inc >= resync_interval_reg)
                                begin
                                    resync_count_next = 16'd0;
                                    req_next          = 1'b1;
                                end
                                else
                                begin
                                    resync_count_next = count_inc;
                                end
                                scan_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        wctt_pkg::FUNC_SET_TIME:
                        begin
                            sec_next  = time_seconds;
                            min_next  = time_minutes;
                            hour_next = time_hours;
                            day_next  = time_day;
                        end
                        wctt_pkg::FUNC_ADD_CD:
                        begin
                            add_kind_next    = wctt_pkg::KIND_COUNTDOWN;
                            add_payload_next = countdown_seconds;
                            state_next       = ST_ADD;
                        end
                        wctt_pkg::FUNC_ADD_SCHED:
                        begin
                            add_kind_next    = wctt_pkg::KIND_SCHEDULED;
                            add_payload_next = {2'b00, time_day, time_hours, time_minutes};
                            state_next       = ST_ADD;
                        end
                        wctt_pkg::FUNC_REMOVE:
                        begin
                            // Drop indexes past the table
                            if (task_index < 8'(wctt_pkg::MAX_TASKS))
                            begin
                                slot_kind_next[wctt_pkg::SLOT_W'(task_index)] =
                                    wctt_pkg::KIND_FREE;
                            end
                        end
                        default:
                        begin
                            // Unknown operation: only the end word follows
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                rd_addr = (advance && (scan_idx_reg != LAST_SLOT)) ?
                          scan_idx_reg + wctt_pkg::SLOT_W'(1) : scan_idx_reg;
                if (advance)
                begin
                    if (cur_kind == wctt_pkg::KIND_COUNTDOWN)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = scan_idx_reg;
                        mem_wdata = dec_payload;
                    end
                    if (fire)
                    begin
                        slot_kind_next[scan_idx_reg] = wctt_pkg::KIND_FREE;
                        out_load         = 1'b1;
                        out_kind_next    = wctt_pkg::RES_FIRED;
                        out_slot_next    = 3'(scan_idx_reg);
                        out_success_next = 1'b0;
                        out_req_next     = 1'b0;
                        out_last_next    = 1'b0;
                    end
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + wctt_pkg::SLOT_W'(1);
                    end
                end
            end

            ST_ADD:
            begin
                if (out_room)
                begin
                    out_load         = 1'b1;
                    out_kind_next    = wctt_pkg::RES_ADD_ACK;
                    out_req_next     = 1'b0;
                    out_last_next    = 1'b0;
                    out_success_next = free_found;
                    out_slot_next    = free_found ? 3'(free_idx) : 3'd0;
                    if (free_found)
                    begin
                        slot_kind_next[free_idx] = add_kind_reg;
                        mem_we    = 1'b1;
                        mem_waddr = free_idx;
                        mem_wdata = add_payload_reg;
                    end
                    state_next = ST_END;
                end
            end

            ST_END:
            begin
                if (out_room)
                begin
                    out_load         = 1'b1;
                    out_kind_next    = wctt_pkg::RES_END;
                    out_slot_next    = 3'd0;
                    out_success_next = 1'b0;
                    out_req_next     = req_reg;
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            scan_idx_reg        <= '0;
            resync_interval_reg <= wctt_pkg::RESYNC_RESET;
            resync_count_reg    <= 16'd0;
            req_reg             <= 1'b0;
            sec_reg             <= 6'd0;
            min_reg             <= 6'd0;
            hour_reg            <= 5'd0;
            day_reg             <= 3'd0;
            out_valid_reg       <= 1'b0;
            for (int i = 0; i < wctt_pkg::MAX_TASKS; i++)
            begin
                slot_kind_reg[i] <= wctt_pkg::KIND_FREE;
            end
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            resync_count_reg <= resync_count_next;
            req_reg          <= req_next;
            sec_reg          <= sec_next;
            min_reg          <= min_next;
            hour_reg         <= hour_next;
            day_reg          <= day_next;
            out_valid_reg    <= out_valid_next;
            slot_kind_reg    <= slot_kind_next;
            if (cfg_we)
            begin
                resync_interval_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        add_kind_reg    <= add_kind_next;
        add_payload_reg <= add_payload_next;
        if (out_load)
        begin
            out_kind_reg    <= out_kind_next;
            out_slot_reg    <= out_slot_next;
            out_success_reg <= out_success_next;
            out_req_reg     <= out_req_next;
            out_last_reg    <= out_last_next;
            // Snapshot the clock so a waiting word is not disturbed by the next item
            out_sec_reg     <= sec_reg;
            out_min_reg     <= min_reg;
            out_hour_reg    <= hour_reg;
            out_day_reg     <= day_reg;
        end
    end

    // Payload memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= payload_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign slot_index   = out_slot_reg;
    assign success      = out_success_reg;
    assign request_time = out_req_reg;
    assign now_seconds  = out_sec_reg;
    assign now_minutes  = out_min_reg;
    assign now_hours    = out_hour_reg;
    assign now_day      = out_day_reg;
    assign last         = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, state_reg != ST_IDLE, "accepted word left sequencer idle")
    `ASSERT_NEXT(a_invalid_tick_skips_scan, clk, rst_n, in_fire && (func == wctt_pkg::FUNC_TICK) && (day_reg == 3'd0), (state_reg == ST_END) && req_reg, "tick on invalid clock did not go straight to end")
    `ASSERT_SAME(a_mem_write_state, clk, rst_n, mem_we, (state_reg == ST_SCAN) || (state_reg == ST_ADD), "payload write outside scan or add")
    `ASSERT_NEXT(a_end_word_last, clk, rst_n, (state_reg == ST_END) && out_room, out_valid_reg && out_last_reg && (state_reg == ST_IDLE), "end word not loaded as last")

endmodule

FILE: test/weekly_clock_task_timer_tb.sv
// Self-checking testbench for the weekly clock task timer.
`timescale 1ns / 1ps
module weekly_clock_task_timer_tb;

    // Operation codes the block must ignore: end word only, no state change
    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam int HALF_PERIOD = 4;
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int LONG_HOLD   = 300;   // receiver back-pressure stretch
    localparam int SETTLE      = 12;    // covers the longest tick walk of the slot table

    // One input word, one field per port
    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [2:0]  day;
        logic [15:0] cd;
        logic [7:0]  idx;
    } op_word_t;

    // One result word as it leaves the block
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic       ok;
        logic       req;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [2:0] day;
        logic       last;
    } res_word_t;

    // Directed row: the word, and when fixed is set the end word typed in by hand
    typedef struct packed {
        op_word_t  op;
        logic      fixed;
        res_word_t exp;
    } dir_row_t;

    localparam res_word_t NO_END = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    op_word_t    drive_word = '0;
    logic        drive_fixed = 1'b0;
    res_word_t   drive_exp = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [2:0]  slot_index;
    logic        success;
    logic        request_time;
    logic [5:0]  now_seconds;
    logic [5:0]  now_minutes;
    logic [4:0]  now_hours;
    logic [2:0]  now_day;
    logic        last;

    // Shadow of the block: wall clock, slot table, resync counter and register
    logic [5:0]  wall_s = '0;
    logic [5:0]  wall_m = '0;
    logic [4:0]  wall_h = '0;
    logic [2:0]  wall_d = '0;
    wctt_pkg::slot_kind_t task_kind [wctt_pkg::MAX_TASKS];
    wctt_pkg::payload_t   task_load [wctt_pkg::MAX_TASKS];
    logic [15:0] ticks_since_sync = '0;
    logic [15:0] resync_every = wctt_pkg::RESYNC_RESET;

    res_word_t   due_results [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    weekly_clock_task_timer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (drive_word.func),
        .time_seconds      (drive_word.sec),
        .time_minutes      (drive_word.min),
        .time_hours        (drive_word.hr),
        .time_day          (drive_word.day),
        .countdown_seconds (drive_word.cd),
        .task_index        (drive_word.idx),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .slot_index        (slot_index),
        .success           (success),
        .request_time      (request_time),
        .now_seconds       (now_seconds),
        .now_minutes       (now_minutes),
        .now_hours         (now_hours),
        .now_day           (now_day),
        .last              (last)
    );

    initial begin
        foreach (task_kind[i])
        begin
            task_kind[i] = wctt_pkg::KIND_FREE;
            task_load[i] = '0;
        end
    end

    function automatic op_word_t mk_op(logic [2:0] f, logic [5:0] s, logic [5:0] m,
                                       logic [4:0] h, logic [2:0] d, logic [15:0] cd,
                                       logic [7:0] idx);
        return '{f, s, m, h, d, cd, idx};
    endfunction

    function automatic res_word_t end_at(logic req, logic [5:0] s, logic [5:0] m,
                                         logic [4:0] h, logic [2:0] d);
        return '{wctt_pkg::RES_END, 3'd0, 1'b0, req, s, m, h, d, 1'b1};
    endfunction

    // Build a result word stamped with the shadow clock as it stands now
    function automatic res_word_t wall_word(logic [1:0] k, wctt_pkg::slot_idx_t s,
                                            logic ok, logic req, logic lst);
        return '{k, 3'(s), ok, req, wall_s, wall_m, wall_h, wall_d, lst};
    endfunction

    // Apply one accepted word to the shadow state and queue every word it causes
    task automatic timer_step(input op_word_t w, input logic fixed, input res_word_t fixed_end);
        logic               req;
        logic               fire;
        logic               found;
        wctt_pkg::payload_t load;
        int                 i;
        req = 1'b0;
        case (w.func)
            wctt_pkg::FUNC_TICK:
            begin
                if (wall_d != 3'd0)
                begin
                    // Ripple the carry: each unit at or past its top wraps
                    if (wall_s < 6'd59)
                        wall_s++;
                    else
                    begin
                        wall_s = '0;
                        if (wall_m < 6'd59)
                            wall_m++;
                        else
                        begin
                            wall_m = '0;
                            if (wall_h < 5'd23)
                                wall_h++;
                            else
                            begin
                                wall_h = '0;
                                wall_d = (wall_d < 3'd7) ? wall_d + 3'd1 : 3'd1;
                            end
                        end
                    end
                    // Walk the slots in index order on the advanced clock
                    for (i = 0; i < wctt_pkg::MAX_TASKS; i++)
                    begin
                        fire = 1'b0;
                        if (task_kind[i] == wctt_pkg::KIND_COUNTDOWN)
                        begin
                            task_load[i] = task_load[i] - 16'd1;
                            fire = (task_load[i] == 16'd0);
                        end
                        else if (task_kind[i] == wctt_pkg::KIND_SCHEDULED)
                        begin
                            load = task_load[i];
                            fire = (load[13:11] == wall_d) && (load[10:6] == wall_h) &&
                                   (load[5:0] == wall_m);
                        end
                        if (fire)
                        begin
                            task_kind[i] = wctt_pkg::KIND_FREE;
                            due_results.push_back(wall_word(wctt_pkg::RES_FIRED,
                                                            wctt_pkg::slot_idx_t'(i),
                                                            1'b0, 1'b0, 1'b0));
                        end
                    end
                    ticks_since_sync = ticks_since_sync + 16'd1;
                    if (ticks_since_sync >= resync_every)
                    begin
                        ticks_since_sync = '0;
                        req = 1'b1;
                    end
                end
                else
                    req = 1'b1;  // invalid clock: ask for the time, touch nothing
            end
            wctt_pkg::FUNC_SET_TIME:
            begin
                wall_s = w.sec;
                wall_m = w.min;
                wall_h = w.hr;
                wall_d = w.day;
            end
            wctt_pkg::FUNC_ADD_CD, wctt_pkg::FUNC_ADD_SCHED:
            begin
                found = 1'b0;
                for (i = 0; i < wctt_pkg::MAX_TASKS; i++)
                begin
                    if (!found && task_kind[i] == wctt_pkg::KIND_FREE)
                    begin
                        found = 1'b1;
                        if (w.func == wctt_pkg::FUNC_ADD_CD)
                        begin
                            task_kind[i] = wctt_pkg::KIND_COUNTDOWN;
                            task_load[i] = w.cd;
                        end
                        else
                        begin
                            task_kind[i] = wctt_pkg::KIND_SCHEDULED;
                            task_load[i] = {2'b00, w.day, w.hr, w.min};
                        end
                        due_results.push_back(wall_word(wctt_pkg::RES_ADD_ACK,
                                                        wctt_pkg::slot_idx_t'(i),
                                                        1'b1, 1'b0, 1'b0));
                    end
                end
                if (!found)
                    due_results.push_back(wall_word(wctt_pkg::RES_ADD_ACK, '0,
                                                    1'b0, 1'b0, 1'b0));
            end
            wctt_pkg::FUNC_REMOVE:
            begin
                if (w.idx < wctt_pkg::MAX_TASKS)
                    task_kind[w.idx[wctt_pkg::SLOT_W-1:0]] = wctt_pkg::KIND_FREE;
            end
            default:
            begin
            end
        endcase
        if (fixed)
            due_results.push_back(fixed_end);
        else
            due_results.push_back(wall_word(wctt_pkg::RES_END, '0, 1'b0, req, 1'b1));
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels and the register port at the rising edge.
    // Check the outgoing word first: it can never belong to a word taken this edge.
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with no expected word pending");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("slot_index", 16'(want.slot), 16'(slot_index));
                    check_field("success", 16'(want.ok), 16'(success));
                    check_field("request_time", 16'(want.req), 16'(request_time));
                    check_field("now_seconds", 16'(want.sec), 16'(now_seconds));
                    check_field("now_minutes", 16'(want.min), 16'(now_minutes));
                    check_field("now_hours", 16'(want.hr), 16'(now_hours));
                    check_field("now_day", 16'(want.day), 16'(now_day));
                    check_field("last", 16'(want.last), 16'(last));
                end
            end
            if (in_valid && in_ready)
                timer_step(drive_word, drive_fixed, drive_exp);
            if (cfg_we)
                resync_every = cfg_wdata;
        end
    end

    // Pick the next random word from the shadow state, so most words hit live
    // behavior: ticks on a valid clock, short countdowns, schedules a minute out.
    function automatic op_word_t pick_op();
        op_word_t    w;
        int unsigned roll;
        // Start from noise in every field so unused bits toggle too
        w = mk_op(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                  3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (wall_d == 3'd0 && $urandom_range(0, 99) < 80)
            roll = 50;
        if (roll < 45)
            w.func = wctt_pkg::FUNC_TICK;
        else if (roll < 55)
        begin
            w.func = wctt_pkg::FUNC_SET_TIME;
            if ($urandom_range(0, 99) >= 8)
            begin
                w.day = 3'($urandom_range(1, 7));
                w.hr  = ($urandom_range(0, 1) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
                w.min = ($urandom_range(0, 1) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
                w.sec = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(55, 59)) :
                                                      6'($urandom_range(0, 59));
                if ($urandom_range(0, 99) < 5)
                    w.day = 3'd0;
            end
        end
        else if (roll < 70)
        begin
            w.func = wctt_pkg::FUNC_ADD_CD;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                w.cd = 16'($urandom_range(1, 6));
            else if (roll < 90)
                w.cd = 16'($urandom_range(1, 60));
        end
        else if (roll < 82)
        begin
            w.func = wctt_pkg::FUNC_ADD_SCHED;
            if ($urandom_range(0, 99) < 75)
            begin
                w.day = wall_d;
                w.hr  = wall_h;
                w.min = (wall_m < 6'd59 && $urandom_range(0, 1) != 0) ? wall_m + 6'd1 : wall_m;
            end
        end
        else if (roll < 96)
        begin
            w.func = wctt_pkg::FUNC_REMOVE;
            if ($urandom_range(0, 99) < 75)
                w.idx = 8'($urandom_range(0, wctt_pkg::MAX_TASKS - 1));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: w.func = FUNC_RSVD5;
                1: w.func = FUNC_RSVD6;
                default: w.func = FUNC_RSVD7;
            endcase
        end
        return w;
    endfunction

    // Offer one word and hold it until taken. Start at a falling edge; drop valid
    // only when a gap is inserted, so valid is never lowered and raised in one step.
    task automatic send_op(input bit random_op, input op_word_t w, input logic fixed,
                           input res_word_t fixed_end);
        op_word_t word;
        word = w;
        @(negedge clk);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        if (random_op)
            word = pick_op();
        drive_word  <= word;
        drive_fixed <= fixed;
        drive_exp   <= fixed_end;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_op(1'b1, '0, 1'b0, NO_END);
    endtask

    // Drop valid and hold until every expected word is back, then let the block settle
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_resync(input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: stall at random, and once hold off for a long stretch so the
    // output register fills and the block stops taking input words.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        // Directed words. Typed end words where the outcome is plain: invalid clock,
        // ignored operations, set_time loads. Every other row goes to the predictor.
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                             end_at(1, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_REMOVE, 0, 0, 0, 0, 0, 255), 1'b1,
                             end_at(0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_op(FUNC_RSVD5, 0, 0, 0, 0, 0, 0), 1'b1, end_at(0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_op(FUNC_RSVD6, 0, 0, 0, 0, 0, 0), 1'b1, end_at(0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_op(FUNC_RSVD7, 63, 63, 31, 7, 16'hFFFF, 255), 1'b1,
                             end_at(0, 0, 0, 0, 0)});
        // Fill all eight slots: zero countdown wraps to the full 2^16 ticks
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0,
                             NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 1, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 2, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_SCHED, 0, 59, 23, 7, 0, 0), 1'b0,
                             NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_SCHED, 0, 0, 0, 1, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 3, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_SCHED, 0, 0, 0, 2, 0, 0), 1'b0, NO_END});
        // Table full: this add must fail
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_ADD_CD, 0, 0, 0, 0, 5, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_SET_TIME, 59, 58, 23, 7, 0, 0), 1'b1,
                             end_at(0, 59, 58, 23, 7)});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        // Roll over the end of the week
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_SET_TIME, 59, 59, 23, 7, 0, 0), 1'b1,
                             end_at(0, 59, 59, 23, 7)});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_REMOVE, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_REMOVE, 0, 0, 0, 0, 0, 1), 1'b0, NO_END});
        // Out-of-range time is stored as given, then wraps on the next tick
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_SET_TIME, 63, 63, 31, 7, 0, 0), 1'b1,
                             end_at(0, 63, 63, 31, 7)});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b0, NO_END});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_SET_TIME, 10, 20, 5, 0, 0, 0), 1'b1,
                             end_at(0, 10, 20, 5, 0)});
        dir_rows.push_back('{mk_op(wctt_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                             end_at(1, 10, 20, 5, 0)});

        // Hold reset, then release at a falling edge
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: sender idles lightly, receiver heavily
        tx_idle_pct = 10;
        rx_idle_pct = 71;
        foreach (dir_rows[i])
            send_op(1'b0, dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].exp);
        wait_drain();

        // Resync every valid tick
        write_resync(16'd1);
        run_random(115);
        wait_drain();

        // Zero interval also requests on every valid tick; swap the idling sides
        write_resync(16'd0);
        tx_idle_pct = 71;
        rx_idle_pct = 10;
        run_random(115);
        wait_drain();

        // Largest interval, no idling; hold the receiver off while words keep coming,
        // then pause the sender until everything is back
        write_resync(16'hFFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        run_random(60);
        wait_drain();
        run_random(55);
        wait_drain();

        // Short interval so requests come often
        write_resync(16'($urandom_range(2, 6)));
        run_random(115);
        wait_drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
